// ===== rtl/core/cip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cip_pkg
// Shared types and constants of the compressed-image parser.
// ----------------------------------------------------------------------------
package cip_pkg;

	localparam int STRING_ALIGN_DEFAULT = 4;
	localparam int QUEUE_DEPTH_DEFAULT  = 4;
	localparam logic [31:0] MIN_MESSAGE_BYTES = 32'd26;

	typedef enum logic [1:0] {
		KIND_FORMAT  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_SUMMARY = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK           = 2'd0,
		STATUS_TRUNCATED    = 2'd1,
		STATUS_EMPTY_FORMAT = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_message;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  byte_value;
		logic [31:0] stamp_seconds;
		logic [31:0] stamp_nanoseconds;
		logic [31:0] payload_length;
		status_t     status;
		logic        final_result;
	} result_t;

	// one queue entry holds everything a single input word causes
	typedef struct packed {
		logic        has_byte;
		kind_t       byte_kind;
		logic [7:0]  byte_value;
		logic        has_summary;
		logic [31:0] seconds;
		logic [31:0] nanoseconds;
		logic [31:0] payload_length;
		status_t     status;
	} qentry_t;

endpackage

// ===== rtl/core/cip_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cip_front
// Byte parser: walks the message fields, captures the stamp and lengths,
// and writes one queue entry per word that yields output.
// ----------------------------------------------------------------------------
module cip_front import cip_pkg::*; #(
	parameter int STRING_ALIGN = STRING_ALIGN_DEFAULT
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   item,
	input  logic    q_full,
	output logic    q_wr,
	output qentry_t q_entry
);

	localparam int AW = (STRING_ALIGN > 1) ? $clog2(STRING_ALIGN) : 1;
	localparam logic [AW-1:0] ALIGN_LAST = AW'(STRING_ALIGN - 1);

	typedef enum logic [3:0] {
		PH_HDR, PH_SEC, PH_NSEC, PH_FIDLEN, PH_FID, PH_FIDPAD, PH_FMTLEN,
		PH_FMT, PH_FMTPAD, PH_DATALEN, PH_DATA, PH_DONE, PH_ERR
	} phase_t;

	phase_t      phase_q, phase_nx;
	logic [31:0] pos_q, pos_nx;
	logic [AW-1:0] align_q, align_nx;
	logic [1:0]  shift_q, shift_nx;
	logic [31:0] rem_q, rem_nx;
	logic [31:0] sec_q, sec_nx;
	logic [31:0] nsec_q, nsec_nx;
	logic [31:0] plen_q, plen_nx;
	logic [31:0] word_nx;
	logic        word_done;
	logic        aligned;
	logic        emit;
	kind_t       emit_kind;
	logic        accept;
	status_t     status;

	assign accept = push && !q_full;

	// little-endian word assembly
	assign word_nx   = ((shift_q == 2'd0) ? 32'd0 : rem_q) |
	                   (32'(item.data_byte) << {shift_q, 3'b000});
	assign word_done = (shift_q == 2'd3);

	always_comb begin
		pos_nx   = (pos_q == 32'hFFFF_FFFF) ? pos_q : pos_q + 32'd1;
		align_nx = align_q;
		if (pos_q != 32'hFFFF_FFFF) begin
			align_nx = (align_q == ALIGN_LAST) ? '0 : align_q + AW'(1);
		end
	end

	assign aligned = (align_nx == '0);

	always_comb begin
		phase_nx  = phase_q;
		shift_nx  = shift_q;
		rem_nx    = rem_q;
		sec_nx    = sec_q;
		nsec_nx   = nsec_q;
		plen_nx   = plen_q;
		emit      = 1'b0;
		emit_kind = KIND_FORMAT;
		unique case (phase_q)
			PH_HDR: begin
				shift_nx = shift_q + 2'd1;
				if (word_done) phase_nx = PH_SEC;
			end
			PH_SEC: begin
				shift_nx = shift_q + 2'd1;
				sec_nx = ((shift_q == 2'd0) ? 32'd0 : sec_q) |
				         (32'(item.data_byte) << {shift_q, 3'b000});
				if (word_done) phase_nx = PH_NSEC;
			end
			PH_NSEC: begin
				shift_nx = shift_q + 2'd1;
				nsec_nx = ((shift_q == 2'd0) ? 32'd0 : nsec_q) |
				          (32'(item.data_byte) << {shift_q, 3'b000});
				if (word_done) phase_nx = PH_FIDLEN;
			end
			PH_FIDLEN: begin
				shift_nx = shift_q + 2'd1;
				rem_nx = word_nx;
				if (word_done) phase_nx = PH_FID;
			end
			PH_FID: begin
				rem_nx = rem_q - 32'd1;
			end
			PH_FMTLEN: begin
				shift_nx = shift_q + 2'd1;
				rem_nx = word_nx;
				if (word_done) phase_nx = (word_nx == 32'd0) ? PH_ERR : PH_FMT;
			end
			PH_FMT: begin
				emit   = (rem_q != 32'd1);
				rem_nx = rem_q - 32'd1;
			end
			PH_DATALEN: begin
				shift_nx = shift_q + 2'd1;
				plen_nx = ((shift_q == 2'd0) ? 32'd0 : plen_q) |
				          (32'(item.data_byte) << {shift_q, 3'b000});
				if (word_done) begin
					rem_nx   = plen_nx;
					phase_nx = PH_DATA;
				end
			end
			PH_DATA: begin
				emit      = 1'b1;
				emit_kind = KIND_PAYLOAD;
				rem_nx    = rem_q - 32'd1;
			end
			default: begin
			end
		endcase

		if (phase_nx == PH_FID && rem_nx == 32'd0) phase_nx = PH_FIDPAD;
		if (phase_nx == PH_FIDPAD && aligned) phase_nx = PH_FMTLEN;
		if (phase_nx == PH_FMT && rem_nx == 32'd0) phase_nx = PH_FMTPAD;
		if (phase_nx == PH_FMTPAD && aligned) phase_nx = PH_DATALEN;
		if (phase_nx == PH_DATA && rem_nx == 32'd0) phase_nx = PH_DONE;
	end

	always_comb begin
		priority if (pos_nx < MIN_MESSAGE_BYTES) status = STATUS_TRUNCATED;
		else if (phase_nx == PH_ERR) status = STATUS_EMPTY_FORMAT;
		else if (phase_nx != PH_DONE) status = STATUS_TRUNCATED;
		else status = STATUS_OK;
	end

	assign q_wr = accept && (emit || item.end_of_message);

	always_comb begin
		q_entry.has_byte       = emit;
		q_entry.byte_kind      = emit_kind;
		q_entry.byte_value     = item.data_byte;
		q_entry.has_summary    = item.end_of_message;
		q_entry.seconds        = sec_nx;
		q_entry.nanoseconds    = nsec_nx;
		q_entry.payload_length = plen_nx;
		q_entry.status         = status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR;
			pos_q   <= '0;
			align_q <= '0;
			shift_q <= '0;
			rem_q   <= '0;
			sec_q   <= '0;
			nsec_q  <= '0;
			plen_q  <= '0;
		end else if (accept) begin
			if (item.end_of_message) begin
				phase_q <= PH_HDR;
				pos_q   <= '0;
				align_q <= '0;
				shift_q <= '0;
				rem_q   <= '0;
				sec_q   <= '0;
				nsec_q  <= '0;
				plen_q  <= '0;
			end else begin
				phase_q <= phase_nx;
				pos_q   <= pos_nx;
				align_q <= align_nx;
				shift_q <= shift_nx;
				rem_q   <= rem_nx;
				sec_q   <= sec_nx;
				nsec_q  <= nsec_nx;
				plen_q  <= plen_nx;
			end
		end
	end

	// a closing word restarts the parse from a clean position
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.end_of_message) |=> (pos_q == 32'd0 && phase_q == PH_HDR))
		else $error("parser state not cleared after end of message");

endmodule

// ===== rtl/core/cip_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cip_fifo
// Short queue of parsed entries between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module cip_fifo import cip_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr,
	input  qentry_t wr_entry,
	input  logic    rd,
	output qentry_t head,
	output logic    full,
	output logic    empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

	qentry_t       slots_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign full  = (count_q == COUNT_FULL);
	assign empty = (count_q == '0);
	assign head  = slots_q[rptr_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) slots_q[wptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) wptr_q <= (wptr_q == PTR_LAST) ? '0 : wptr_q + PW'(1);
			if (do_rd) rptr_q <= (rptr_q == PTR_LAST) ? '0 : rptr_q + PW'(1);
			if (do_wr && !do_rd) count_q <= count_q + CW'(1);
			else if (do_rd && !do_wr) count_q <= count_q - CW'(1);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) wr |-> !full)
		else $error("queue written while full");

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= COUNT_FULL)
		else $error("queue count out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> !empty)
		else $error("queue lost a word");

endmodule

// ===== rtl/core/cip_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cip_back
// Result sequencer: turns each queue entry into its byte word and/or its
// summary word, byte first.
// ----------------------------------------------------------------------------
module cip_back import cip_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  qentry_t head,
	input  logic    q_empty,
	output logic    q_rd,
	input  logic    pop,
	output logic    empty,
	output result_t result
);

	logic byte_done_q;
	logic show_byte;
	logic take;

	assign empty     = q_empty;
	assign show_byte = head.has_byte && !byte_done_q;
	assign take      = pop && !q_empty;
	assign q_rd      = take && !(show_byte && head.has_summary);

	always_comb begin
		if (show_byte) begin
			result.kind              = head.byte_kind;
			result.byte_value        = head.byte_value;
			result.stamp_seconds     = '0;
			result.stamp_nanoseconds = '0;
			result.payload_length    = '0;
			result.status            = STATUS_OK;
			result.final_result      = 1'b0;
		end else begin
			result.kind              = KIND_SUMMARY;
			result.byte_value        = '0;
			result.stamp_seconds     = head.seconds;
			result.stamp_nanoseconds = head.nanoseconds;
			result.payload_length    = head.payload_length;
			result.status            = head.status;
			result.final_result      = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_done_q <= 1'b0;
		end else if (q_rd) begin
			byte_done_q <= 1'b0;
		end else if (take) begin
			byte_done_q <= 1'b1;
		end
	end

	// half-delivered entry must still be in the queue
	assert property (@(posedge clk) disable iff (!arst_n) byte_done_q |-> !q_empty)
		else $error("byte marked delivered with no entry");

endmodule

// ===== rtl/core/cdr_compressed_image_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdr_compressed_image_parser_unit
// Streaming parser for a serialized compressed-image message.
// ----------------------------------------------------------------------------
// Takes one message byte per cycle and returns format characters, payload
// bytes and a closing summary word per message. The parser accepts a byte
// every cycle while its output queue (QUEUE_DEPTH entries) has room; the
// result side delivers one word per cycle while pop is high and the queue is
// not empty, except that a closing byte that also carries a payload or format
// byte yields two words, both taken from the same queue entry.
module cdr_compressed_image_parser_unit import cip_pkg::*; #(
	parameter int STRING_ALIGN = STRING_ALIGN_DEFAULT,
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEFAULT
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   item,
	output logic    full,
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	qentry_t wr_entry, head;
	logic    q_wr, q_rd, q_full, q_empty;

	assign full = q_full;

	cip_front #(
		.STRING_ALIGN(STRING_ALIGN)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item(item),
		.q_full(q_full),
		.q_wr(q_wr),
		.q_entry(wr_entry)
	);

	cip_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr(q_wr),
		.wr_entry(wr_entry),
		.rd(q_rd),
		.head(head),
		.full(q_full),
		.empty(q_empty)
	);

	cip_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.q_empty(q_empty),
		.q_rd(q_rd),
		.pop(pop),
		.empty(empty),
		.result(result)
	);

endmodule

// ===== bench/cip_stream_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cip_stream_checker
// Watches both queue ports of the compressed-image parser and checks its words.
// ----------------------------------------------------------------------------
// Every byte accepted on the input side runs through a local copy of the
// parser state. The format characters, payload bytes and closing summaries
// that it yields wait in order. Each word popped from the block is compared
// field by field with the oldest of them. Failures are counted and handed up.
module cip_stream_checker import cip_pkg::*; #(
	parameter int STRING_ALIGN = STRING_ALIGN_DEFAULT
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   item,
	input  logic    full,
	input  logic    empty,
	input  logic    pop,
	input  result_t result,
	output int      fail_count,
	output int      pending,
	output int      format_count,
	output int      payload_count,
	output int      ok_count,
	output int      truncated_count,
	output int      empty_format_count
);

	typedef enum logic [3:0] {
		ST_HDR, ST_SEC, ST_NSEC, ST_FIDLEN, ST_FID, ST_FIDPAD, ST_FMTLEN,
		ST_FMT, ST_FMTPAD, ST_DATALEN, ST_DATA, ST_DONE, ST_ERR
	} parse_state_t;

	parse_state_t state;
	logic [31:0]  position;
	logic [31:0]  shift_bits;
	logic [31:0]  remaining;
	logic [31:0]  seconds;
	logic [31:0]  nanoseconds;
	logic [31:0]  declared_length;
	logic         format_empty;
	result_t      predicted_words [$];

	initial begin
		fail_count = 0;
		pending = 0;
		format_count = 0;
		payload_count = 0;
		ok_count = 0;
		truncated_count = 0;
		empty_format_count = 0;
	end

	task automatic clear_parser();
		state = ST_HDR;
		position = '0;
		shift_bits = '0;
		remaining = '0;
		seconds = '0;
		nanoseconds = '0;
		declared_length = '0;
		format_empty = 1'b0;
	endtask

	// little-endian gather of a 32-bit field
	task automatic take_le_byte(inout logic [31:0] acc, input logic [7:0] b,
			output logic complete);
		if (shift_bits == 0)
			acc = '0;
		acc = acc | (32'(b) << shift_bits);
		shift_bits = shift_bits + 32'd8;
		complete = (shift_bits >= 32);
		if (complete)
			shift_bits = '0;
	endtask

	task automatic add_data_word(input kind_t k, input logic [7:0] b);
		result_t r;
		r = '0;
		r.kind = k;
		r.byte_value = b;
		predicted_words.push_back(r);
	endtask

	task automatic parse_byte(input item_t w);
		logic [31:0] scratch;
		logic        complete;
		result_t     summary;
		scratch = '0;
		complete = 1'b0;
		case (state)
			ST_HDR: begin
				take_le_byte(scratch, w.data_byte, complete);
				if (complete)
					state = ST_SEC;
			end
			ST_SEC: begin
				take_le_byte(seconds, w.data_byte, complete);
				if (complete)
					state = ST_NSEC;
			end
			ST_NSEC: begin
				take_le_byte(nanoseconds, w.data_byte, complete);
				if (complete)
					state = ST_FIDLEN;
			end
			ST_FIDLEN: begin
				take_le_byte(remaining, w.data_byte, complete);
				if (complete)
					state = ST_FID;
			end
			ST_FID: begin
				remaining = remaining - 32'd1;
			end
			ST_FMTLEN: begin
				take_le_byte(remaining, w.data_byte, complete);
				if (complete) begin
					if (remaining == 0) begin
						format_empty = 1'b1;
						state = ST_ERR;
					end else begin
						state = ST_FMT;
					end
				end
			end
			ST_FMT: begin
				// the terminator byte is dropped
				if (remaining != 32'd1)
					add_data_word(KIND_FORMAT, w.data_byte);
				remaining = remaining - 32'd1;
			end
			ST_DATALEN: begin
				take_le_byte(declared_length, w.data_byte, complete);
				if (complete) begin
					remaining = declared_length;
					state = ST_DATA;
				end
			end
			ST_DATA: begin
				add_data_word(KIND_PAYLOAD, w.data_byte);
				remaining = remaining - 32'd1;
			end
			default: begin
			end
		endcase

		if (position != 32'hFFFF_FFFF)
			position = position + 32'd1;

		if (state == ST_FID && remaining == 0)
			state = ST_FIDPAD;
		if (state == ST_FIDPAD && position % STRING_ALIGN == 0)
			state = ST_FMTLEN;
		if (state == ST_FMT && remaining == 0)
			state = ST_FMTPAD;
		if (state == ST_FMTPAD && position % STRING_ALIGN == 0)
			state = ST_DATALEN;
		if (state == ST_DATA && remaining == 0)
			state = ST_DONE;

		if (w.end_of_message) begin
			summary = '0;
			summary.kind = KIND_SUMMARY;
			summary.stamp_seconds = seconds;
			summary.stamp_nanoseconds = nanoseconds;
			summary.payload_length = declared_length;
			summary.final_result = 1'b1;
			if (position < MIN_MESSAGE_BYTES)
				summary.status = STATUS_TRUNCATED;
			else if (format_empty)
				summary.status = STATUS_EMPTY_FORMAT;
			else if (state != ST_DONE)
				summary.status = STATUS_TRUNCATED;
			else
				summary.status = STATUS_OK;
			predicted_words.push_back(summary);
			clear_parser();
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	task automatic check_word(input result_t got);
		result_t want;
		if (predicted_words.size() == 0) begin
			fail_count++;
			$display("%0t: unexpected word, expected none, actual %h", $time, got);
		end else begin
			want = predicted_words.pop_front();
			check_field("kind", 32'(want.kind), 32'(got.kind));
			check_field("byte_value", 32'(want.byte_value), 32'(got.byte_value));
			check_field("stamp_seconds", want.stamp_seconds, got.stamp_seconds);
			check_field("stamp_nanoseconds", want.stamp_nanoseconds,
				got.stamp_nanoseconds);
			check_field("payload_length", want.payload_length, got.payload_length);
			check_field("status", 32'(want.status), 32'(got.status));
			check_field("final_result", 32'(want.final_result), 32'(got.final_result));
			case (want.kind)
				KIND_FORMAT: format_count++;
				KIND_PAYLOAD: payload_count++;
				default: begin
					case (want.status)
						STATUS_OK: ok_count++;
						STATUS_TRUNCATED: truncated_count++;
						default: empty_format_count++;
					endcase
				end
			endcase
		end
	endtask

	// sampled in the active region of the edge, before the block updates
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parser();
			predicted_words.delete();
		end else begin
			if (pop && !empty)
				check_word(result);
			if (push && !full)
				parse_byte(item);
		end
		pending = predicted_words.size();
	end

endmodule

// ===== bench/tb_cdr_compressed_image_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cdr_compressed_image_parser_unit
// Message-level stimulus for the compressed-image parser.
// ----------------------------------------------------------------------------
// Builds serialized messages byte by byte: a few hand-picked ones for the
// edge cases (tiny, minimal, empty format, cut-off payload, huge lengths),
// then a random mix that is mostly well formed, with cut-off, empty-format,
// huge-length and garbage messages mixed in. Both queue sides stall at
// random; the receiver also blocks for a long stretch so the input backs up.
// Checking lives in cip_stream_checker; this module reports the verdict.
module tb_cdr_compressed_image_parser_unit;
	import cip_pkg::*;

	localparam int RANDOM_WORDS = 230;
	localparam int IDLE_PERCENT = 24;
	localparam int HOLD_CYCLES  = 80;
	localparam int CYCLE_LIMIT  = 200000;

	logic    clk;
	logic    arst_n;
	logic    push;
	item_t   item;
	logic    full;
	logic    empty;
	logic    pop;
	result_t result;

	int fail_count;
	int pending;
	int format_count;
	int payload_count;
	int ok_count;
	int truncated_count;
	int empty_format_count;

	int    idle_pct = IDLE_PERCENT;
	int    hold_len = 0;
	int    cycle_count = 0;
	int    message_count = 0;
	int    word_count = 0;
	item_t msg_bytes [$];

	cdr_compressed_image_parser_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (full),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	cip_stream_checker u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.push               (push),
		.item               (item),
		.full               (full),
		.empty              (empty),
		.pop                (pop),
		.result             (result),
		.fail_count         (fail_count),
		.pending            (pending),
		.format_count       (format_count),
		.payload_count      (payload_count),
		.ok_count           (ok_count),
		.truncated_count    (truncated_count),
		.empty_format_count (empty_format_count)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycle_count, pending);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result side: random stalls, plus one long block on request
	initial begin
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				pop <= 1'b0;
				hold_len--;
			end else begin
				pop <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	task automatic put_random(input int n);
		repeat (n)
			msg_bytes.push_back(item_t'({8'($urandom), 1'b0}));
	endtask

	task automatic put_word32(input logic [31:0] v);
		for (int i = 0; i < 4; i++)
			msg_bytes.push_back(item_t'({v[8*i +: 8], 1'b0}));
	endtask

	task automatic pad_to_align();
		while (msg_bytes.size() % STRING_ALIGN_DEFAULT != 0)
			put_random(1);
	endtask

	task automatic set_bytes(input int first, input int last, input logic [7:0] v);
		for (int i = first; i < last; i++)
			msg_bytes[i].data_byte = v;
	endtask

	task automatic build_message(input logic [31:0] fid_decl, input int fid_body,
			input int fmt_len, input logic [31:0] pay_decl, input int pay_body,
			input int trailing);
		msg_bytes.delete();
		put_random(12);
		put_word32(fid_decl);
		put_random(fid_body);
		pad_to_align();
		put_word32(32'(fmt_len));
		put_random(fmt_len);
		pad_to_align();
		put_word32(pay_decl);
		put_random(pay_body + trailing);
	endtask

	task automatic send_word(input item_t w);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= w;
		@(negedge clk);
		while (full)
			@(negedge clk);
		@(posedge clk);
		word_count++;
	endtask

	task automatic send_message(input int keep);
		msg_bytes[keep - 1].end_of_message = 1'b1;
		for (int i = 0; i < keep; i++)
			send_word(msg_bytes[i]);
		message_count++;
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int pick;
		int keep;
		int fid_len;
		int fmt_len;
		int pay_len;
		int trail;
		int start_words;

		push = 1'b0;
		item = '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// one-byte message
		msg_bytes.delete();
		msg_bytes.push_back(item_t'({8'hFF, 1'b0}));
		send_message(1);

		// minimal complete message, zero stamps, terminator-only format
		build_message(32'd0, 0, 1, 32'd0, 0, 0);
		set_bytes(0, 12, 8'h00);
		send_message(msg_bytes.size());

		// all-ones stamps, extreme payload bytes, trailing junk
		build_message(32'd1, 1, 3, 32'd2, 2, 2);
		set_bytes(4, 12, 8'hFF);
		msg_bytes[32].data_byte = 8'hFF;
		msg_bytes[33].data_byte = 8'h00;
		send_message(msg_bytes.size());

		// empty format string
		build_message(32'd2, 2, 0, 32'd3, 3, 0);
		send_message(msg_bytes.size());

		// message ends inside the payload
		build_message(32'd0, 0, 2, 32'd5, 5, 0);
		send_message(30);

		// frame id that never ends
		build_message(32'hFFFF_FFFF, 10, 1, 32'd0, 0, 0);
		send_message(msg_bytes.size());

		// payload that never ends
		build_message(32'd0, 0, 2, 32'hFFFF_FFFF, 6, 0);
		send_message(msg_bytes.size());

		// shorter than the fixed minimum
		build_message(32'd0, 0, 1, 32'd0, 0, 0);
		send_message(20);

		wait_drained();

		start_words = word_count;
		for (int m = 0; word_count - start_words < RANDOM_WORDS; m++) begin
			if (m == 1)
				hold_len = HOLD_CYCLES;
			if (m == 2)
				idle_pct = 0;
			if (m == 5) begin
				idle_pct = IDLE_PERCENT;
				wait_drained();
			end
			pick = $urandom_range(99);
			fid_len = $urandom_range(6);
			fmt_len = $urandom_range(6, 1);
			pay_len = $urandom_range(10);
			trail = ($urandom_range(3) == 0) ? $urandom_range(4, 1) : 0;
			if (pick < 60) begin
				build_message(32'(fid_len), fid_len, fmt_len, 32'(pay_len), pay_len, trail);
				keep = msg_bytes.size();
			end else if (pick < 75) begin
				build_message(32'(fid_len), fid_len, fmt_len, 32'(pay_len), pay_len, trail);
				keep = $urandom_range(msg_bytes.size(), 1);
			end else if (pick < 83) begin
				build_message(32'(fid_len), fid_len, 0, 32'(pay_len), pay_len, trail);
				keep = msg_bytes.size();
			end else if (pick < 87) begin
				build_message($urandom, 8, fmt_len, 32'(pay_len), pay_len, 0);
				keep = msg_bytes.size();
			end else if (pick < 91) begin
				build_message(32'(fid_len), fid_len, fmt_len, $urandom, pay_len, 0);
				keep = msg_bytes.size();
			end else begin
				msg_bytes.delete();
				put_random($urandom_range(30, 1));
				keep = msg_bytes.size();
			end
			send_message(keep);
		end

		wait_drained();
		$display("sent %0d messages in %0d bytes; checked %0d format chars, %0d payload bytes",
			message_count, word_count, format_count, payload_count);
		$display("message summaries: %0d ok, %0d truncated, %0d empty format",
			ok_count, truncated_count, empty_format_count);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/cip_pkg.sv
rtl/core/cip_front.sv
rtl/core/cip_fifo.sv
rtl/core/cip_back.sv
rtl/core/cdr_compressed_image_parser_unit.sv
bench/cip_stream_checker.sv
bench/tb_cdr_compressed_image_parser_unit.sv
